[design/flow_affinity_dispatch_table_unit_defines.svh]
// Assertion macros shared by the checker of the flow affinity dispatch table.
// Expects signals named clock and reset in the scope of each use.
`ifndef FLOW_AFFINITY_DISPATCH_TABLE_UNIT_DEFINES_SVH
`define FLOW_AFFINITY_DISPATCH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FADT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FADT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fadt_pkg.sv]
// Package of the flow affinity dispatch table: sizes, codes, item and slot types.
// Used by the top level, the hash unit and the checker by scoped names; depends on nothing.
package fadt_pkg;

   localparam int BUCKETS     = 256;
   localparam int WAYS        = 4;
   localparam int MAX_TARGETS = 8;

   localparam int SLOTS    = BUCKETS * WAYS;
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ISSUE_W  = $clog2(WAYS + 1);
   localparam bit BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   localparam int FID_W    = 64;
   localparam int TARGET_W = 3;
   localparam int COUNT_W  = 4;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int HASH_W   = 32;
   localparam int TARGET_LIMIT = (MAX_TARGETS < 8) ? MAX_TARGETS : 8;

   // Hash unit step counts: one byte per step, then one remainder bit per step.
   localparam int HASH_STEPS = 16;
   localparam int MOD_STEPS  = HASH_W;
   localparam int STEP_W     = 5;

   localparam logic [OP_W-1:0] OP_SELECT = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [FID_W-1:0]    fid_high;
      logic [FID_W-1:0]    fid_low;
      logic [TARGET_W-1:0] target_index;
   } fadt_req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] chosen_target;
      logic                hit;
      logic [STATUS_W-1:0] status;
   } fadt_rsp_type;

   typedef struct packed {
      logic [FID_W-1:0]    fid_high;
      logic [FID_W-1:0]    fid_low;
      logic [TARGET_W-1:0] target;
   } fadt_slot_type;

   localparam int SLOT_BITS = $bits(fadt_slot_type);

   typedef enum logic [1:0] {
      HP_IDLE,
      HP_HASH,
      HP_MOD
   } fadt_hash_phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_VRD,
      ST_SCAN,
      ST_COMMIT
   } fadt_state_type;

endpackage

[design/flow_affinity_dispatch_table_unit.sv]
// Flow affinity dispatch table. Each item hashes its 128-bit file id with the sdbm rule
// and looks it up in a bucket of WAYS slots: a select returns the stored target or the
// next round-robin target, an insert fills the lowest free slot, a remove frees the
// lowest matching slot. After reset the block clears every slot valid row and takes no
// item meanwhile; csr writes are taken at any time. Once an item is accepted, the shared
// hash adder folds one id byte per cycle, and the slot memory delivers one way per cycle
// to the single id comparator. A bucket count that is not a power of two adds a
// bit-serial remainder pass. The next item is accepted as soon as the result is
// registered, even while that result still waits on rsp_ready.
// Depends on fadt_pkg, fadt_hash and fadt_ram.
module flow_affinity_dispatch_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fadt_pkg::fadt_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fadt_pkg::fadt_rsp_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fadt_pkg::COUNT_W-1:0]  csr_data
);

   localparam int WAYS  = fadt_pkg::WAYS;
   localparam int SW    = fadt_pkg::SLOT_W;
   localparam int BW    = fadt_pkg::BUCKET_W;
   localparam int WW    = fadt_pkg::WAY_W;
   localparam int IW    = fadt_pkg::ISSUE_W;
   localparam int TW    = fadt_pkg::TARGET_W;

   fadt_pkg::fadt_state_type state_ff, state_in;
   logic [BW-1:0]            clr_ff, clr_in;
   fadt_pkg::fadt_req_type   req_ff, req_in;
   logic [SW-1:0]            base_ff, base_in;
   logic [IW-1:0]            issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   logic [WW-1:0]            pend_way_ff, pend_way_in;
   logic                     match_ff, match_in;
   logic [WW-1:0]            match_way_ff, match_way_in;
   logic [TW-1:0]            match_tgt_ff, match_tgt_in;
   logic [TW-1:0]            rr_ff, rr_in;
   logic [fadt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   fadt_pkg::fadt_rsp_type   rsp_ff, rsp_in;

   logic                     accept;
   logic                     rsp_free;
   logic                     hash_done;
   logic [BW-1:0]            hash_bucket;
   logic [31:0]              base_wide;

   logic                     vwr_en;
   logic [BW-1:0]            vwr_addr;
   logic [WAYS-1:0]          vwr_data;
   logic [WAYS-1:0]          vrow;

   logic                     id_wr_en;
   logic [fadt_pkg::SLOT_BITS-1:0] id_wr_data;
   logic                     id_rd_en;
   logic [SW-1:0]            id_rd_addr;
   logic [fadt_pkg::SLOT_BITS-1:0] id_rd_data;
   fadt_pkg::fadt_slot_type  slot_rd;
   fadt_pkg::fadt_slot_type  slot_wr;

   logic                     full;
   logic [WW-1:0]            free_way;
   logic [fadt_pkg::COUNT_W-1:0] rr_inc;
   logic [TW-1:0]            rr_next;
   logic                     csr_legal;

   assign req_ready = (state_ff == fadt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fadt_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .fid    ({req_data.fid_high, req_data.fid_low}),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // One row per bucket, one valid bit per way.
   fadt_ram #(
      .WIDTH (WAYS),
      .DEPTH (fadt_pkg::BUCKETS)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vwr_addr),
      .wr_data (vwr_data),
      .rd_en   (state_ff == fadt_pkg::ST_VRD),
      .rd_addr (hash_bucket),
      .rd_data (vrow)
   );

   fadt_ram #(
      .WIDTH (fadt_pkg::SLOT_BITS),
      .DEPTH (fadt_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (id_wr_en),
      .wr_addr (base_ff + SW'(free_way)),
      .wr_data (id_wr_data),
      .rd_en   (id_rd_en),
      .rd_addr (id_rd_addr),
      .rd_data (id_rd_data)
   );

   assign slot_rd    = id_rd_data;
   assign id_wr_data = slot_wr;
   assign id_rd_en   = (state_ff == fadt_pkg::ST_SCAN) && (issue_ff != IW'(WAYS));
   assign id_rd_addr = base_ff + SW'(issue_ff);
   assign base_wide  = 32'(hash_bucket) * 32'(WAYS);

   assign slot_wr.fid_high = req_ff.fid_high;
   assign slot_wr.fid_low  = req_ff.fid_low;
   assign slot_wr.target   = req_ff.target_index;

   always_comb begin
      full     = &vrow;
      free_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!vrow[i]) begin
            free_way = WW'(i);
         end
      end
   end

   // The pointer always stays below the count, so the wrap is a single compare.
   assign rr_inc  = {1'b0, rr_ff} + 4'd1;
   assign rr_next = (rr_inc == count_ff) ? '0 : rr_inc[TW-1:0];

   assign csr_legal = (csr_data != '0) &&
                      (csr_data <= fadt_pkg::COUNT_W'(fadt_pkg::TARGET_LIMIT));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      base_in      = base_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_way_in  = pend_way_ff;
      match_in     = match_ff;
      match_way_in = match_way_ff;
      match_tgt_in = match_tgt_ff;
      rr_in        = rr_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vwr_en       = 1'b0;
      vwr_addr     = hash_bucket;
      vwr_data     = vrow;
      id_wr_en     = 1'b0;

      case (state_ff)
         fadt_pkg::ST_CLEAR: begin
            vwr_en   = 1'b1;
            vwr_addr = clr_ff;
            vwr_data = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == BW'(fadt_pkg::BUCKETS - 1)) begin
               state_in = fadt_pkg::ST_IDLE;
            end
         end
         fadt_pkg::ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = fadt_pkg::ST_HASH;
            end
         end
         fadt_pkg::ST_HASH: begin
            if (hash_done) begin
               state_in = fadt_pkg::ST_VRD;
            end
         end
         fadt_pkg::ST_VRD: begin
            base_in  = base_wide[SW-1:0];
            issue_in = '0;
            pend_in  = 1'b0;
            match_in = 1'b0;
            state_in = fadt_pkg::ST_SCAN;
         end
         fadt_pkg::ST_SCAN: begin
            // The way read last cycle is compared while the next way is read.
            if (pend_ff && vrow[pend_way_ff] && !match_ff &&
                (slot_rd.fid_high == req_ff.fid_high) &&
                (slot_rd.fid_low == req_ff.fid_low)) begin
               match_in     = 1'b1;
               match_way_in = pend_way_ff;
               match_tgt_in = slot_rd.target;
            end
            if (issue_ff == IW'(WAYS)) begin
               pend_in  = 1'b0;
               state_in = fadt_pkg::ST_COMMIT;
            end else begin
               pend_in     = 1'b1;
               pend_way_in = WW'(issue_ff);
               issue_in    = issue_ff + 1'b1;
            end
         end
         fadt_pkg::ST_COMMIT: begin
            if (rsp_free) begin
               state_in      = fadt_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               vwr_addr      = hash_bucket;
               rsp_in.hit    = match_ff && ((req_ff.op == fadt_pkg::OP_SELECT) ||
                                            (req_ff.op == fadt_pkg::OP_INSERT) ||
                                            (req_ff.op == fadt_pkg::OP_REMOVE));
               case (req_ff.op)
                  fadt_pkg::OP_SELECT: begin
                     if (match_ff) begin
                        rsp_in.chosen_target = match_tgt_ff;
                     end else begin
                        rr_in                = rr_next;
                        rsp_in.chosen_target = rr_next;
                     end
                  end
                  fadt_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_in.status = fadt_pkg::STATUS_FULL;
                     end else begin
                        id_wr_en = 1'b1;
                        vwr_en   = 1'b1;
                        vwr_data = vrow | (WAYS'(1) << free_way);
                     end
                  end
                  fadt_pkg::OP_REMOVE: begin
                     if (!match_ff) begin
                        rsp_in.status = fadt_pkg::STATUS_NOT_FOUND;
                     end else begin
                        vwr_en   = 1'b1;
                        vwr_data = vrow & ~(WAYS'(1) << match_way_ff);
                     end
                  end
                  default: begin
                     rsp_in.status = fadt_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = fadt_pkg::ST_IDLE;
         end
      endcase

      // A legal count restarts the round-robin sequence.
      if (csr_valid && csr_ready && csr_legal) begin
         count_in = csr_data;
         rr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fadt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rr_ff        <= '0;
         count_ff     <= fadt_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         match_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rr_ff        <= rr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         match_ff     <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      base_ff      <= base_in;
      issue_ff     <= issue_in;
      pend_way_ff  <= pend_way_in;
      match_way_ff <= match_way_in;
      match_tgt_ff <= match_tgt_in;
      rsp_ff       <= rsp_in;
   end

endmodule

[design/fadt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the slot valid rows and the slot contents.
module fadt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fadt_hash.sv]
// Iterative sdbm hash of a 128-bit file id, one byte per cycle, reduced to a bucket.
// Depends on fadt_pkg; the remainder pass runs only for a bucket count off a power of two.
module fadt_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*fadt_pkg::FID_W-1:0]   fid,
   output logic                           done,
   output logic [fadt_pkg::BUCKET_W-1:0]  bucket
);

   localparam int FIDS_W = 2 * fadt_pkg::FID_W;
   localparam int BW     = fadt_pkg::BUCKET_W;

   fadt_pkg::fadt_hash_phase_type phase_ff, phase_in;
   logic [FIDS_W-1:0]            data_ff, data_in;
   logic [fadt_pkg::HASH_W-1:0]  h_ff, h_in;
   logic [fadt_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [BW-1:0]                rem_ff, rem_in;
   logic                         done_ff, done_in;

   logic [fadt_pkg::HASH_W-1:0]  step;
   logic [BW:0]                  trial;
   logic [BW:0]                  trial_sub;

   // sdbm: byte + (h << 6) + (h << 16) - h, wrapping at 32 bits.
   assign step = {24'd0, data_ff[FIDS_W-1 -: 8]} + (h_ff << 6) + (h_ff << 16) - h_ff;

   // Restoring remainder: shift in the next hash bit, subtract the bucket count if it fits.
   assign trial     = {rem_ff, h_ff[fadt_pkg::HASH_W-1]};
   assign trial_sub = trial - (BW + 1)'(fadt_pkg::BUCKETS);

   always_comb begin
      phase_in = phase_ff;
      data_in  = data_ff;
      h_in     = h_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (phase_ff)
         fadt_pkg::HP_IDLE: begin
            if (start) begin
               data_in  = fid;
               h_in     = '0;
               cnt_in   = '0;
               phase_in = fadt_pkg::HP_HASH;
            end
         end
         fadt_pkg::HP_HASH: begin
            h_in    = step;
            data_in = data_ff << 8;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == fadt_pkg::STEP_W'(fadt_pkg::HASH_STEPS - 1)) begin
               cnt_in = '0;
               if (fadt_pkg::BUCKETS_POW2) begin
                  rem_in   = BW'(step & 32'(fadt_pkg::BUCKETS - 1));
                  done_in  = 1'b1;
                  phase_in = fadt_pkg::HP_IDLE;
               end else begin
                  rem_in   = '0;
                  phase_in = fadt_pkg::HP_MOD;
               end
            end
         end
         fadt_pkg::HP_MOD: begin
            if (trial >= (BW + 1)'(fadt_pkg::BUCKETS)) begin
               rem_in = trial_sub[BW-1:0];
            end else begin
               rem_in = trial[BW-1:0];
            end
            h_in   = h_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == fadt_pkg::STEP_W'(fadt_pkg::MOD_STEPS - 1)) begin
               done_in  = 1'b1;
               phase_in = fadt_pkg::HP_IDLE;
            end
         end
         default: begin
            phase_in = fadt_pkg::HP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fadt_pkg::HP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      h_ff    <= h_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

[design/fadt_checker.sv]
// Port-level checker for the flow affinity dispatch table, bound to the top level.
// Depends on fadt_pkg and the assertion macros in the defines header.
`include "flow_affinity_dispatch_table_unit_defines.svh"

module fadt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fadt_pkg::fadt_rsp_type rsp_data
);

   // An accepted item keeps the block busy for the following cycle at least.
   `FADT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // A waiting result holds until it is taken.
   `FADT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed")

   // A failed item carries no target: only a select picks a target, and a select always reports ok.
   `FADT_ASSERT_SAME(a_status_no_target, rsp_valid && rsp_data.status != fadt_pkg::STATUS_OK, rsp_data.chosen_target == '0, "target on failed item")

   // A remove that found nothing cannot have hit.
   `FADT_ASSERT_SAME(a_not_found_no_hit, rsp_valid && rsp_data.status == fadt_pkg::STATUS_NOT_FOUND, !rsp_data.hit, "hit on remove miss")

endmodule

bind flow_affinity_dispatch_table_unit fadt_checker u_fadt_checker (.*);
